@@ src/packed_sprite_pixel_expander_defines.svh @@
// Assertion macros for the packed sprite pixel expander.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PACKED_SPRITE_PIXEL_EXPANDER_DEFINES_SVH
`define PACKED_SPRITE_PIXEL_EXPANDER_DEFINES_SVH

// same-cycle implication
`define PSPE_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSPE_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pspe_pkg.sv @@
// Shared types, constants and helpers for the packed sprite pixel expander.
// No dependencies.
package pspe_pkg;

    localparam int PAL_DEPTH     = 256;
    localparam int PAL_AW        = $clog2(PAL_DEPTH);
    localparam int MAX_ROW_WORDS = 1024;
    localparam int BIR_W         = $clog2(MAX_ROW_WORDS * 4);
    localparam int PITCH_W       = BIR_W + 1;
    localparam int POS_W         = (BIR_W + 3 > 16) ? BIR_W + 3 : 16;
    localparam int FIFO_DEPTH    = 2;
    localparam int APB_AW        = 5;

    localparam logic [31:0] MASK_OFF = 32'hFF00_0000;

    localparam logic [2:0] REG_BPP_LOG     = 3'd0;
    localparam logic [2:0] REG_WIDTH       = 3'd1;
    localparam logic [2:0] REG_ROW_WORDS   = 3'd2;
    localparam logic [2:0] REG_HAS_MASK    = 3'd3;
    localparam logic [2:0] REG_MASK_COLOUR = 3'd4;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    typedef struct packed {
        logic [1:0]  bpp_log;
        logic [15:0] width_pixels;
        logic [10:0] row_words;
        logic        has_mask;
        logic [31:0] mask_colour;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        bpp_log:      2'd3,
        width_pixels: 16'd1,
        row_words:    11'd1,
        has_mask:     1'b0,
        mask_colour:  MASK_OFF
    };

    typedef struct packed {
        logic        op;
        logic [7:0]  sprite_byte;
        logic [7:0]  mask_byte;
        logic [7:0]  palette_index;
        logic [23:0] palette_colour;
        logic [3:0]  count;
        logic        eor_valid;
        logic [2:0]  eor_k;
    } entry_t;

    function automatic logic [23:0] swap_rb(input logic [23:0] c);
        return {c[7:0], c[15:8], c[23:16]};
    endfunction

endpackage

@@ src/pspe_if.sv @@
// Valid/ready channel interfaces for input words and pixel words.
// No dependencies.
interface pspe_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  sprite_byte;
    logic [7:0]  mask_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_colour;

    modport source (output valid, operation, sprite_byte, mask_byte, palette_index,
                    palette_colour, input ready);
    modport sink (input valid, operation, sprite_byte, mask_byte, palette_index,
                  palette_colour, output ready);
endinterface

interface pspe_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_colour;
    logic        end_of_row;
    logic        last_of_item;

    modport source (output valid, pixel_colour, end_of_row, last_of_item, input ready);
    modport sink (input valid, pixel_colour, end_of_row, last_of_item, output ready);
endinterface

@@ src/pspe_regs.sv @@
// APB configuration registers.
// Depends on pspe_pkg.
module pspe_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pspe_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output pspe_pkg::cfg_t            cfg
);

    pspe_pkg::cfg_t cfg_reg;
    pspe_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;

    assign reg_idx = paddr[pspe_pkg::APB_AW-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (reg_idx)
                pspe_pkg::REG_BPP_LOG:     cfg_next.bpp_log      = pwdata[1:0];
                pspe_pkg::REG_WIDTH:       cfg_next.width_pixels = pwdata[15:0];
                pspe_pkg::REG_ROW_WORDS:   cfg_next.row_words    = pwdata[10:0];
                pspe_pkg::REG_HAS_MASK:    cfg_next.has_mask     = pwdata[0];
                pspe_pkg::REG_MASK_COLOUR: cfg_next.mask_colour  = pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pspe_pkg::REG_BPP_LOG:     prdata = {30'd0, cfg_reg.bpp_log};
            pspe_pkg::REG_WIDTH:       prdata = {16'd0, cfg_reg.width_pixels};
            pspe_pkg::REG_ROW_WORDS:   prdata = {21'd0, cfg_reg.row_words};
            pspe_pkg::REG_HAS_MASK:    prdata = {31'd0, cfg_reg.has_mask};
            pspe_pkg::REG_MASK_COLOUR: prdata = cfg_reg.mask_colour;
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= pspe_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

@@ src/pspe_front.sv @@
// Front end: accepts input words, tracks the byte position in the row and
// works out how many pixels of each byte are visible. Depends on pspe_pkg, pspe_if.
module pspe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  pspe_pkg::cfg_t      cfg,
    pspe_in_if.sink             sprite,
    input  logic                full,
    output logic                push,
    output pspe_pkg::entry_t    push_entry
);

    logic [pspe_pkg::BIR_W-1:0]   bir_reg;
    logic [pspe_pkg::BIR_W-1:0]   bir_next;
    logic [pspe_pkg::BIR_W-1:0]   cur_bir;
    logic [10:0]                  rw_eff;
    logic [pspe_pkg::PITCH_W-1:0] pitch;
    logic [pspe_pkg::PITCH_W-1:0] nb;
    logic [pspe_pkg::POS_W-1:0]   base;
    logic [pspe_pkg::POS_W-1:0]   width_ext;
    logic [pspe_pkg::POS_W-1:0]   rem;
    logic [pspe_pkg::POS_W-1:0]   rem_m1;
    logic [pspe_pkg::POS_W-1:0]   ppb_ext;
    logic [3:0]                   ppb;
    logic                         vis;
    logic                         accept;

    always_comb
    begin
        if (cfg.row_words == 11'd0)
            rw_eff = 11'd1;
        else if (int'(cfg.row_words) > pspe_pkg::MAX_ROW_WORDS)
            rw_eff = 11'(pspe_pkg::MAX_ROW_WORDS);
        else
            rw_eff = cfg.row_words;
    end

    assign pitch     = pspe_pkg::PITCH_W'(rw_eff) << 2;
    assign cur_bir   = (pspe_pkg::PITCH_W'(bir_reg) >= pitch) ? '0 : bir_reg;
    assign nb        = pspe_pkg::PITCH_W'(cur_bir) + 1'b1;
    assign bir_next  = (nb >= pitch) ? '0 : nb[pspe_pkg::BIR_W-1:0];

    assign ppb       = 4'd8 >> cfg.bpp_log;
    assign ppb_ext   = pspe_pkg::POS_W'(ppb);
    assign base      = pspe_pkg::POS_W'(cur_bir) << (2'd3 - cfg.bpp_log);
    assign width_ext = pspe_pkg::POS_W'(cfg.width_pixels);
    assign vis       = width_ext > base;
    assign rem       = width_ext - base;
    assign rem_m1    = rem - 1'b1;

    always_comb
    begin
        push_entry.op             = sprite.operation;
        push_entry.sprite_byte    = sprite.sprite_byte;
        push_entry.mask_byte      = sprite.mask_byte;
        push_entry.palette_index  = sprite.palette_index;
        push_entry.palette_colour = sprite.palette_colour;
        push_entry.count          = !vis ? 4'd0 : ((rem >= ppb_ext) ? ppb : rem[3:0]);
        push_entry.eor_valid      = vis && (rem <= ppb_ext);
        push_entry.eor_k          = rem_m1[2:0];
    end

    assign sprite.ready = !full;
    assign accept       = sprite.valid && !full;
    assign push         = accept &&
                          ((sprite.operation == pspe_pkg::OP_PALETTE) ||
                           (push_entry.count != 4'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bir_reg <= '0;
        else if (accept && (sprite.operation == pspe_pkg::OP_PIXEL))
            bir_reg <= bir_next;
    end

endmodule

@@ src/pspe_fifo.sv @@
// Short queue of classified words between front and back end.
// Depends on pspe_pkg.
module pspe_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pspe_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output pspe_pkg::entry_t pop_entry,
    output logic             empty
);

    localparam int PTR_W = (pspe_pkg::FIFO_DEPTH > 1) ? $clog2(pspe_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(pspe_pkg::FIFO_DEPTH + 1);

    pspe_pkg::entry_t fifo_mem_reg [pspe_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(pspe_pkg::FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = fifo_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(pspe_pkg::FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(pspe_pkg::FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ src/pspe_back.sv @@
// Back end: steps through the pixels of each byte, looks them up in the palette
// and drives the pixel channel. Depends on pspe_pkg, pspe_if.
module pspe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pspe_pkg::cfg_t   cfg,
    input  logic             q_empty,
    input  pspe_pkg::entry_t q_entry,
    output logic             q_pop,
    pspe_out_if.source       pixel
);

    logic [23:0]      pal_mem [pspe_pkg::PAL_DEPTH];

    pspe_pkg::entry_t cur_reg;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [2:0]       k_reg;
    logic [2:0]       k_next;

    logic             pv_reg;
    logic             pv_next;
    logic             use_mask_reg;
    logic             eor_reg;
    logic             last_reg;
    logic             oor_reg;
    logic [23:0]      rdata_reg;

    logic             adv;
    logic             issue;
    logic             last_k;
    logic             seq_free;
    logic             load;
    logic             pal_we;
    logic [2:0]       sh;
    logic [3:0]       bpp;
    logic [8:0]       fm_w;
    logic [7:0]       ci;
    logic [7:0]       mi;
    logic             masking;
    logic             ci_in_range;
    logic [23:0]      colour;

    assign adv      = !pv_reg || pixel.ready;
    assign issue    = cur_valid_reg && adv;
    assign last_k   = ({1'b0, k_reg} == (cur_reg.count - 4'd1));
    assign seq_free = !cur_valid_reg || (issue && last_k);
    assign q_pop    = seq_free && !q_empty;
    assign load     = q_pop && (q_entry.op == pspe_pkg::OP_PIXEL);
    assign pal_we   = q_pop && (q_entry.op == pspe_pkg::OP_PALETTE) &&
                      (int'(q_entry.palette_index) < pspe_pkg::PAL_DEPTH);

    assign sh      = 3'(k_reg << cfg.bpp_log);
    assign bpp     = 4'd1 << cfg.bpp_log;
    assign fm_w    = (9'd1 << bpp) - 9'd1;
    assign masking = cfg.has_mask && (cfg.mask_colour != pspe_pkg::MASK_OFF);

    always_comb
    begin
        ci = (cur_reg.sprite_byte >> sh) & fm_w[7:0];
        mi = (cur_reg.mask_byte >> sh) & fm_w[7:0];
        if (cfg.bpp_log == 2'd0)
            ci = ci ^ 8'd1;
    end

    assign ci_in_range = (int'(ci) < pspe_pkg::PAL_DEPTH);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        k_next         = k_reg;
        if (seq_free)
            cur_valid_next = load;
        if (load)
            k_next = 3'd0;
        else if (issue)
            k_next = k_reg + 3'd1;
        pv_next = issue ? 1'b1 : (pixel.ready ? 1'b0 : pv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            k_reg         <= 3'd0;
            pv_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            k_reg         <= k_next;
            pv_reg        <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_entry;
        if (issue)
        begin
            use_mask_reg <= masking && (mi == 8'd0);
            eor_reg      <= cur_reg.eor_valid && (k_reg == cur_reg.eor_k);
            last_reg     <= last_k;
            oor_reg      <= !ci_in_range;
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[q_entry.palette_index[pspe_pkg::PAL_AW-1:0]] <= q_entry.palette_colour;
        if (issue)
            rdata_reg <= pal_mem[ci[pspe_pkg::PAL_AW-1:0]];
    end

    assign colour = use_mask_reg ? cfg.mask_colour[23:0]
                  : (oor_reg ? 24'd0 : rdata_reg);

    assign pixel.valid        = pv_reg;
    assign pixel.pixel_colour = pspe_pkg::swap_rb(colour);
    assign pixel.end_of_row   = eor_reg;
    assign pixel.last_of_item = last_reg;

endmodule

@@ src/packed_sprite_pixel_expander.sv @@
// Packed sprite pixel expander, top level.
// Depends on pspe_pkg, pspe_if, pspe_regs, pspe_front, pspe_fifo, pspe_back.
//
// Image words expand into 8, 4, 2 or 1 pixel words (1, 2, 4, 8 bpp), lowest
// bits first; pixels past width_pixels are dropped. The back end issues one
// pixel word per cycle while the pixel channel is ready; a palette write gives
// no pixel word, and an image word with no visible pixel is not queued.
// That rate is set by the single read port of the 256-entry palette memory.
// An input word is written into the queue, then loaded into cur_reg, and its
// pixels are registered at the output. Registers sit at byte offsets 4*i.
`include "packed_sprite_pixel_expander_defines.svh"

module packed_sprite_pixel_expander (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pspe_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    pspe_in_if.sink                     sprite,
    pspe_out_if.source                  pixel
);

    pspe_pkg::cfg_t   cfg;
    pspe_pkg::entry_t q_in;
    pspe_pkg::entry_t q_entry;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;

    assign pready = 1'b1;

    pspe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pspe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sprite     (sprite),
        .full       (q_full),
        .push       (q_push),
        .push_entry (q_in)
    );

    pspe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .empty      (q_empty)
    );

    pspe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .pixel   (pixel)
    );

    `PSPE_CHECK_NOW(a_push_not_full, q_push, !q_full, "push into full queue")
    `PSPE_CHECK_NOW(a_pop_not_empty, q_pop, !q_empty, "pop from empty queue")
    `PSPE_CHECK_NEXT(a_push_fills, q_push, !q_empty, "pushed word lost")
    `PSPE_CHECK_NOW(a_eor_is_last, pixel.valid && pixel.end_of_row, pixel.last_of_item, "end of row not last pixel of word")

endmodule
